/* hw/rtl/bhw_pkg.sv */
// Shared widths, operation codes and payload types of the Bio-Haar wavelet step
package bhw_pkg;

    localparam int VW = 32;            // value width, signed Q16.16
    localparam int AW = 32;            // area width, unsigned
    localparam int PW = VW + AW + 2;   // width of one lane product
    localparam int NW = PW + 2;        // width of the sum of four products

    localparam logic OP_FWD = 1'b0;    // forward analysis
    localparam logic OP_INV = 1'b1;    // inverse synthesis

    typedef struct packed {
        logic                 operation;
        logic signed [VW-1:0] parent_value;
        logic signed [VW-1:0] child_value_0;
        logic signed [VW-1:0] child_value_1;
        logic signed [VW-1:0] child_value_2;
        logic signed [VW-1:0] child_value_3;
        logic [AW-1:0]        child_area_0;
        logic [AW-1:0]        child_area_1;
        logic [AW-1:0]        child_area_2;
        logic [AW-1:0]        child_area_3;
        logic [AW-1:0]        parent_area;
    } t_in;

    typedef struct packed {
        logic signed [VW-1:0] scaling_out;
        logic signed [VW-1:0] result_0;
        logic signed [VW-1:0] result_1;
        logic signed [VW-1:0] result_2;
        logic signed [VW-1:0] result_3;
        logic                 divide_error;
    } t_out;

    // Data that rides along the product and divider pipeline
    typedef struct packed {
        logic                 op;
        logic                 err;
        logic [AW-1:0]        dvs;
        logic signed [VW-1:0] c0;   // forward: child value; inverse: rebuilt child
        logic signed [VW-1:0] c1;
        logic signed [VW-1:0] c2;
        logic signed [VW-1:0] s;    // inverse: parent scaling
    } t_side;

endpackage

/* hw/rtl/bhw_lane.sv */
// One multiply lane: signed value times unsigned area, registered product
module bhw_lane
    import bhw_pkg::*;
(
    input  logic                 i_clk,
    input  logic signed [VW:0]   i_val,
    input  logic [AW-1:0]        i_area,
    output logic signed [PW-1:0] o_prod
);

    logic signed [PW-1:0] r_prod;

    // Register the exact product
    always_ff @(posedge i_clk) begin
        r_prod <= i_val * $signed({1'b0, i_area});
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/bhw_div.sv */
// Pipelined restoring divider: signed sum by unsigned area, truncated and saturated
module bhw_div
    import bhw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [NW-1:0] i_num,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic signed [VW-1:0] o_q,
    output t_side                o_side
);

    localparam int QW = VW + 1;

    // Stage A: magnitude and sign
    logic          r_a_vld;
    logic [NW-1:0] r_a_mag;
    logic          r_a_neg;
    t_side         r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg  <= i_num[NW-1];
        r_a_mag  <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        r_a_side <= i_side;
    end

    // Stage B and the quotient steps; entry QW is stage B, entry j is after bit j
    logic          r_vld  [0:QW];
    logic [NW-1:0] r_rem  [0:QW];
    logic [QW-1:0] r_q    [0:QW];
    logic          r_neg  [0:QW];
    logic          r_ovf  [0:QW];
    t_side         r_side [0:QW];

    // Flag a quotient that needs more than QW bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[QW] <= 1'b0;
        end else begin
            r_vld[QW] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[QW]  <= r_a_mag;
        r_q[QW]    <= '0;
        r_neg[QW]  <= r_a_neg;
        r_ovf[QW]  <= (r_a_mag >> QW) >= NW'(r_a_side.dvs);
        r_side[QW] <= r_a_side;
    end

    // Resolve one quotient bit per stage
    for (genvar j = QW - 1; j >= 0; j--) begin : g_step
        logic [NW-1:0] w_sub;
        logic          w_ge;

        assign w_sub = NW'(r_side[j+1].dvs) << j;
        assign w_ge  = r_rem[j+1] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= r_vld[j+1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= w_ge ? r_rem[j+1] - w_sub : r_rem[j+1];
            r_q[j]    <= r_q[j+1] | (QW'(w_ge) << j);
            r_neg[j]  <= r_neg[j+1];
            r_ovf[j]  <= r_ovf[j+1];
            r_side[j] <= r_side[j+1];
        end
    end

    // Final stage: clamp to the signed range and restore the sign
    logic [QW-1:0] w_lim;
    logic [QW-1:0] w_mag;

    assign w_lim = r_neg[0] ? (QW'(1) << (VW - 1)) : ((QW'(1) << (VW - 1)) - QW'(1));
    assign w_mag = (r_ovf[0] || (r_q[0] > w_lim)) ? w_lim : r_q[0];

    logic                 r_o_vld;
    logic signed [VW-1:0] r_o_q;
    t_side                r_o_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_q    <= r_neg[0] ? VW'(-w_mag) : VW'(w_mag);
        r_o_side <= r_side[0];
    end

    assign o_vld  = r_o_vld;
    assign o_q    = r_o_q;
    assign o_side = r_o_side;

endmodule

/* hw/rtl/triangle_biohaar_wavelet_step_unit.sv */
// Top level of the area-weighted Bio-Haar wavelet step for one parent triangle
//
// Usage: drive i_in and raise start for one cycle per parent group. busy is
// always low: a group is taken in every cycle that start is high, so a sweep
// can stream one group per clock.
// Forward analysis returns the area-weighted scaling, three corner wavelets
// and a zero central coefficient; inverse synthesis returns the parent
// scaling, three rebuilt corners and the rebuilt central child.
// Each result appears on o_out for exactly one cycle with o_done high, after
// the operand, lane, merge, divider and output registers.
// The restoring divider resolves one quotient bit per pipeline stage; four
// multiply lanes form the products in parallel.
// A zero divisor area sets divide_error and zeroes every value.
// The receiver cannot stall the results; there is no back-pressure.
// Synchronous reset drops every group in flight and no o_done follows.
module triangle_biohaar_wavelet_step_unit
    import bhw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_done,
    output t_out o_out
);

    localparam int LAT = VW + 9;

    function automatic logic [VW-1:0] f_sat(input logic [VW+1:0] t);
        logic [VW-1:0] r;
        if ((t[VW+1] == t[VW]) && (t[VW] == t[VW-1])) begin
            r = t[VW-1:0];
        end else if (t[VW+1]) begin
            r = {1'b1, {(VW-1){1'b0}}};
        end else begin
            r = {1'b0, {(VW-1){1'b1}}};
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // Operand selection for the four lanes
    logic [VW-1:0]      w_res [3];
    logic [VW-1:0]      w_cv  [3];
    logic [AW-1:0]      w_ca  [3];
    logic signed [VW:0] n_lv  [4];
    logic [AW-1:0]      n_la  [4];
    t_side              n_side;

    assign w_cv[0] = i_in.child_value_0;
    assign w_cv[1] = i_in.child_value_1;
    assign w_cv[2] = i_in.child_value_2;
    assign w_ca[0] = i_in.child_area_0;
    assign w_ca[1] = i_in.child_area_1;
    assign w_ca[2] = i_in.child_area_2;

    for (genvar k = 0; k < 3; k++) begin : g_corner
        assign w_res[k] = f_sat({w_cv[k][VW-1], w_cv[k], 1'b0}
                                + {{2{i_in.parent_value[VW-1]}}, i_in.parent_value});
        assign n_lv[k]  = (i_in.operation == OP_INV)
                          ? -$signed({w_res[k][VW-1], w_res[k]})
                          : $signed({w_cv[k][VW-1], w_cv[k]});
        assign n_la[k]  = w_ca[k];
    end

    assign n_lv[3] = (i_in.operation == OP_INV)
                     ? $signed({i_in.parent_value[VW-1], i_in.parent_value})
                     : $signed({i_in.child_value_3[VW-1], i_in.child_value_3});
    assign n_la[3] = (i_in.operation == OP_INV) ? i_in.parent_area : i_in.child_area_3;

    always_comb begin
        n_side.op  = i_in.operation;
        n_side.dvs = (i_in.operation == OP_INV) ? i_in.child_area_3 : i_in.parent_area;
        n_side.err = (n_side.dvs == '0);
        n_side.c0  = (i_in.operation == OP_INV) ? w_res[0] : w_cv[0];
        n_side.c1  = (i_in.operation == OP_INV) ? w_res[1] : w_cv[1];
        n_side.c2  = (i_in.operation == OP_INV) ? w_res[2] : w_cv[2];
        n_side.s   = i_in.parent_value;
    end

    // Stage 1: register lane operands
    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    logic signed [VW:0] r1_lv [4];
    logic [AW-1:0]      r1_la [4];
    t_side              r1_side, r2_side, r3_side, r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_lv   <= n_lv;
        r1_la   <= n_la;
        r1_side <= n_side;
        r2_side <= r1_side;
        r3_side <= r2_side;
        r4_side <= r3_side;
    end

    // Stage 2: four multiply lanes
    logic signed [PW-1:0] w_prod [4];

    for (genvar k = 0; k < 4; k++) begin : g_lane
        bhw_lane u_lane (
            .i_clk  (i_clk),
            .i_val  (r1_lv[k]),
            .i_area (r1_la[k]),
            .o_prod (w_prod[k])
        );
    end

    // Stages 3 and 4: merge the lane products
    logic signed [NW-1:0] r3_p01, r3_p23, r4_sum;

    always_ff @(posedge i_clk) begin
        r3_p01 <= NW'(w_prod[0]) + NW'(w_prod[1]);
        r3_p23 <= NW'(w_prod[2]) + NW'(w_prod[3]);
        r4_sum <= r3_p01 + r3_p23;
    end

    // Divide by the selected area
    logic                 w_dv_vld;
    logic signed [VW-1:0] w_q;
    t_side                w_dv_side;

    bhw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r4_vld),
        .i_num   (r4_sum),
        .i_side  (r4_side),
        .o_vld   (w_dv_vld),
        .o_q     (w_q),
        .o_side  (w_dv_side)
    );

    // Output stage: form the corner wavelets, pass the rebuilt values, or zero all on a divide error
    logic [VW-1:0] w_cs  [3];
    logic [VW-1:0] w_hlf [3];
    t_out          n_out;

    assign w_cs[0] = w_dv_side.c0;
    assign w_cs[1] = w_dv_side.c1;
    assign w_cs[2] = w_dv_side.c2;

    for (genvar k = 0; k < 3; k++) begin : g_half
        logic [VW:0] w_d;
        logic [VW:0] w_r;
        assign w_d      = {w_cs[k][VW-1], w_cs[k]} - {w_q[VW-1], w_q};
        assign w_r      = w_d + (VW+1)'(w_d[VW]);
        assign w_hlf[k] = w_r[VW:1];
    end

    always_comb begin
        n_out = '0;
        if (w_dv_side.err) begin
            n_out.divide_error = 1'b1;
        end else if (w_dv_side.op == OP_INV) begin
            n_out.scaling_out = w_dv_side.s;
            n_out.result_0    = w_cs[0];
            n_out.result_1    = w_cs[1];
            n_out.result_2    = w_cs[2];
            n_out.result_3    = w_q;
        end else begin
            n_out.scaling_out = w_q;
            n_out.result_0    = w_hlf[0];
            n_out.result_1    = w_hlf[1];
            n_out.result_2    = w_hlf[2];
        end
    end

    logic r_done;
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    // Every result traces back to a transfer a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without a matching transfer");

    // A zero divisor clears every value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.divide_error) |->
        (o_out.scaling_out == '0 && o_out.result_0 == '0 && o_out.result_1 == '0
         && o_out.result_2 == '0 && o_out.result_3 == '0))
        else $error("divide error with nonzero values");

    // Forward analysis leaves the central child at zero
    a_fwd_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_in.operation, LAT) == OP_FWD) |-> (o_out.result_3 == '0))
        else $error("forward central coefficient not zero");

endmodule

/* tb/sv/triangle_biohaar_wavelet_step_unit_test.sv */
// Self-checking testbench of the area-weighted Bio-Haar wavelet step unit
`timescale 1ns / 100ps

module triangle_biohaar_wavelet_step_unit_test;
    import bhw_pkg::*;

    localparam int LATENCY   = VW + 9;
    localparam int STALL_MAX = 5000;
    localparam int N_RANDOM  = 640;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_in;
    logic busy;
    logic o_done;
    t_out o_out;

    t_out butterfly_q[$];
    int   n_errors;
    int   stall_cycles;
    int   idle_pct;

    typedef struct {
        t_in  stim;
        bit   typed;
        t_out res;
    } t_row;

    triangle_biohaar_wavelet_step_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Clamp a wide signed value to the value width
    function automatic logic signed [VW-1:0] clamp_value(logic signed [127:0] x);
        if (x > 128'sd2147483647) return {1'b0, {(VW-1){1'b1}}};
        if (x < -128'sd2147483648) return {1'b1, {(VW-1){1'b0}}};
        return x[VW-1:0];
    endfunction

    // Compute the expected butterfly for one parent group
    function automatic t_out butterfly(t_in x);
        logic signed [127:0] cv [4];
        logic signed [127:0] av [4];
        logic signed [127:0] pa;
        logic signed [127:0] acc;
        logic signed [127:0] sv;
        logic signed [VW-1:0] r [4];
        logic signed [VW-1:0] s;
        logic err;
        t_out y;
        cv[0] = x.child_value_0;
        cv[1] = x.child_value_1;
        cv[2] = x.child_value_2;
        cv[3] = x.child_value_3;
        av[0] = {96'b0, x.child_area_0};
        av[1] = {96'b0, x.child_area_1};
        av[2] = {96'b0, x.child_area_2};
        av[3] = {96'b0, x.child_area_3};
        pa  = {96'b0, x.parent_area};
        err = 1'b0;
        s   = '0;
        for (int i = 0; i < 4; i++) r[i] = '0;
        if (x.operation == OP_FWD) begin
            acc = 0;
            for (int i = 0; i < 4; i++) acc += cv[i] * av[i];
            if (pa == 0) begin
                err = 1'b1;
            end else begin
                s  = clamp_value(acc / pa);
                sv = s;
                for (int i = 0; i < 3; i++) r[i] = clamp_value((cv[i] - sv) / 2);
            end
        end else begin
            s   = x.parent_value;
            sv  = s;
            acc = sv * pa;
            for (int i = 0; i < 3; i++) begin
                r[i] = clamp_value(2 * cv[i] + sv);
                acc -= 128'(r[i]) * av[i];
            end
            if (av[3] == 0) err = 1'b1;
            else r[3] = clamp_value(acc / av[3]);
        end
        if (err) begin
            s = '0;
            for (int i = 0; i < 4; i++) r[i] = '0;
        end
        y.scaling_out  = s;
        y.result_0     = r[0];
        y.result_1     = r[1];
        y.result_2     = r[2];
        y.result_3     = r[3];
        y.divide_error = err;
        return y;
    endfunction

    task automatic report_mismatch(string field, logic [VW-1:0] got, logic [VW-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
        n_errors++;
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (butterfly_q.size() == 0) begin
                report_mismatch("unexpected transfer", VW'(1), VW'(0));
            end else begin
                t_out want;
                want = butterfly_q.pop_front();
                if (o_out.scaling_out !== want.scaling_out)
                    report_mismatch("scaling_out", o_out.scaling_out, want.scaling_out);
                if (o_out.result_0 !== want.result_0)
                    report_mismatch("result_0", o_out.result_0, want.result_0);
                if (o_out.result_1 !== want.result_1)
                    report_mismatch("result_1", o_out.result_1, want.result_1);
                if (o_out.result_2 !== want.result_2)
                    report_mismatch("result_2", o_out.result_2, want.result_2);
                if (o_out.result_3 !== want.result_3)
                    report_mismatch("result_3", o_out.result_3, want.result_3);
                if (o_out.divide_error !== want.divide_error)
                    report_mismatch("divide_error", VW'(o_out.divide_error),
                                    VW'(want.divide_error));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Hold one group on the inputs until its transfer
    task automatic send_group(t_in x, bit typed, t_out res);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_in  <= x;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        butterfly_q.push_back(typed ? res : butterfly(x));
    endtask

    function automatic logic [VW-1:0] rand_value();
        case ($urandom_range(5))
            0: return {1'b0, {(VW-1){1'b1}}};
            1: return {1'b1, {(VW-1){1'b0}}};
            2: return 32'($signed($urandom_range(262143)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [AW-1:0] rand_area();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic t_in rand_group();
        t_in x;
        x.operation     = 1'($urandom_range(1));
        x.parent_value  = rand_value();
        x.child_value_0 = rand_value();
        x.child_value_1 = rand_value();
        x.child_value_2 = rand_value();
        x.child_value_3 = rand_value();
        x.child_area_0  = rand_area();
        x.child_area_1  = rand_area();
        x.child_area_2  = rand_area();
        x.child_area_3  = rand_area();
        // mostly a consistent mesh: parent area is the sum of the children
        if ($urandom_range(3) != 0)
            x.parent_area = x.child_area_0 + x.child_area_1 + x.child_area_2
                          + x.child_area_3;
        else
            x.parent_area = rand_area();
        if (x.parent_area == 0 && $urandom_range(3) != 0) x.parent_area = 1;
        if (x.child_area_3 == 0 && $urandom_range(3) != 0) x.child_area_3 = 1;
        return x;
    endfunction

    initial begin
        t_row rows[$];
        t_row row;
        t_out zero;
        t_in  x;
        int   pct [4];
        n_errors     = 0;
        stall_cycles = 0;
        idle_pct     = 0;
        pct          = '{0, 49, 0, 31};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_in         = '0;
        zero         = '0;

        // Directed table
        row.typed = 1'b1;
        row.stim = '0; row.stim.parent_area = 1;
        row.res = zero;
        rows.push_back(row);
        // zero parent area in forward flags divide error
        row.stim = '0; row.stim.operation = OP_FWD;
        row.stim.child_value_0 = 32'h0001_0000; row.stim.child_area_0 = 5;
        row.res = zero; row.res.divide_error = 1'b1;
        rows.push_back(row);
        // zero central area in inverse flags divide error
        row.stim = '0; row.stim.operation = OP_INV; row.stim.parent_value = 32'h0002_0000;
        row.stim.parent_area = 9; row.stim.child_area_0 = 3;
        row.res = zero; row.res.divide_error = 1'b1;
        rows.push_back(row);
        // largest values over unit areas saturate the scaling
        row.stim = '0; row.stim.operation = OP_FWD;
        row.stim.child_value_0 = 32'h7fff_ffff; row.stim.child_value_1 = 32'h7fff_ffff;
        row.stim.child_value_2 = 32'h7fff_ffff; row.stim.child_value_3 = 32'h7fff_ffff;
        row.stim.child_area_0 = 1; row.stim.child_area_1 = 1;
        row.stim.child_area_2 = 1; row.stim.child_area_3 = 1; row.stim.parent_area = 1;
        row.res = zero; row.res.scaling_out = 32'h7fff_ffff;
        rows.push_back(row);
        row.stim = '0; row.stim.operation = OP_INV; row.stim.child_area_3 = 1;
        row.res = zero;
        rows.push_back(row);
        row.typed = 1'b0;
        for (int k = 0; k < 16; k++) begin
            x = '0;
            x.operation     = k[0] ? OP_INV : OP_FWD;
            x.parent_value  = k[1] ? 32'h8000_0000 : 32'h7fff_ffff;
            x.child_value_0 = k[2] ? 32'h8000_0000 : 32'h7fff_ffff;
            x.child_value_1 = k[1] ? 32'hffff_ffff : 32'h0000_0001;
            x.child_value_2 = k[3] ? 32'h8000_0000 : 32'h0001_8000;
            x.child_value_3 = k[2] ? 32'h7fff_ffff : 32'h8000_0000;
            x.child_area_0  = k[3] ? '1 : 32'd1;
            x.child_area_1  = k[2] ? '1 : 32'd7;
            x.child_area_2  = k[1] ? 32'd3 : '1;
            x.child_area_3  = k[3] ? '1 : 32'd1;
            x.parent_area   = k[2] ? '1 : 32'd1;
            row.stim = x;
            rows.push_back(row);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_group(rows[i].stim, rows[i].typed, rows[i].res);

        // Random groups across idling phases
        for (int i = 0; i < N_RANDOM; i++) begin
            idle_pct = pct[(i * 4) / N_RANDOM];
            send_group(rand_group(), 1'b0, zero);
        end
        start <= 1'b0;

        // Drain the pipeline
        while (butterfly_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
